>>> src/sfps_pkg.sv
// shared types and constants of the serial flash program sequencer
`timescale 1ns / 1ps
package sfps_pkg;

  // serial action codes
  typedef enum logic [1:0] {
    ACT_SEND  = 2'd0,
    ACT_RAISE = 2'd1,
    ACT_WAIT  = 2'd2
  } act_t;

  // request kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_ERASE = 2'd2;

  // device code that selects the auto-address-increment mode
  localparam logic [15:0] ID_AAI = 16'hBF4A;

  // flash opcodes
  localparam logic [7:0] OP_AAI   = 8'hAD;
  localparam logic [7:0] OP_BP    = 8'h02;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_WRDI  = 8'h04;
  localparam logic [7:0] OP_ERASE = 8'h20;

  // register index of the device code
  localparam logic REG_DEVICE_ID = 1'b0;

  // most actions one request can cause
  localparam int MAX_ACTS = 12;

  // one queued serial action
  typedef struct packed {
    act_t       action;
    logic [7:0] data;
  } ent_t;

  // build an action, byte forced to zero unless it is a send
  function automatic ent_t mk_ent(act_t a, logic [7:0] b);
    ent_t e;
    e.action = a;
    e.data   = (a == ACT_SEND) ? b : 8'h00;
    return e;
  endfunction

endpackage

>>> src/spi_flash_program_sequencer.sv
// serial flash program and erase sequencer, top level
//
//  channel | direction | handshake                 | payload
//  in_     | input     | in_tvalid / in_tready     | tuser kind, tdata address, length, data
//  out_    | output    | out_tvalid / out_tready   | tuser action, tdata byte, tlast last
//  cfg_    | input     | apb psel/penable, pready=1| device_id at byte address 0
//
// a request is held in an input register until the action queue is free, then all of its actions
// (up to twelve) are worked out in one pass and loaded into the action queue
// the queue drains one action per cycle while out_tready is high; the next request waits
// in the input register meanwhile
// synchronous active-low reset clears all control state and device_id
// out_tready low simply holds the current action; nothing is dropped
`timescale 1ns / 1ps
module spi_flash_program_sequencer
  import sfps_pkg::*;
#(
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // address[23:0], length[39:24], data_byte[47:40]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // action channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // byte_out[7:0]
  output logic [1:0]  out_tuser,  // action[1:0]
  output logic        out_tlast,
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam logic [23:0] RECIP = 24'((64'd1 << 24) / PAGE_BYTES);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(PAGE_BYTES - 1);
  localparam logic [23:0] PAGE_W = 24'(PAGE_BYTES);

  // register port
  logic [15:0] device_id_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_DEVICE_ID) ? {16'h0000, device_id_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= 16'h0000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_DEVICE_ID) begin
      device_id_r <= cfg_pwdata[15:0];
    end
  end

  // input register
  logic        in_valid_r;
  logic [1:0]  kind_r;
  logic [23:0] addr_r;
  logic [15:0] len_r;
  logic [7:0]  dbyte_r;
  logic [23:0] qest_r;
  logic [47:0] qprod;
  logic        load;
  logic        seq_free;
  logic        out_go;

  assign qprod     = in_tdata[23:0] * RECIP;
  assign in_tready = !in_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (load) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload of the held request, with a page quotient estimate
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r  <= in_tuser;
      addr_r  <= in_tdata[23:0];
      len_r   <= in_tdata[39:24];
      dbyte_r <= in_tdata[47:40];
      qest_r  <= qprod[47:24];
    end
  end

  // write state
  logic             wa_r,   wa_nxt;
  logic             aai_r,  aai_nxt;
  logic [23:0]      na_r,   na_nxt;
  logic [23:0]      fa_r,   fa_nxt;
  logic [15:0]      bl_r,   bl_nxt;
  logic [7:0]       hb_r,   hb_nxt;
  logic             hv_r,   hv_nxt;
  logic             st_r,   st_nxt;
  logic [OFF_W-1:0] off_r,  off_nxt;

  // page offset of the start address
  logic [23:0]      rem_w;
  logic [OFF_W-1:0] start_off;
  logic [23:0]      bp_addr;

  assign rem_w     = addr_r - 24'(qest_r * PAGE_W);
  assign start_off = (rem_w >= PAGE_W) ? OFF_W'(rem_w - PAGE_W) : OFF_W'(rem_w);
  assign bp_addr   = (bl_r == 16'd1) ? fa_r : na_r;

  // action list for the held request
  ent_t       seq_nxt [MAX_ACTS];
  logic [3:0] n;

  always_comb begin
    wa_nxt  = wa_r;
    aai_nxt = aai_r;
    na_nxt  = na_r;
    fa_nxt  = fa_r;
    bl_nxt  = bl_r;
    hb_nxt  = hb_r;
    hv_nxt  = hv_r;
    st_nxt  = st_r;
    off_nxt = off_r;
    n       = 4'd0;
    for (int i = 0; i < MAX_ACTS; i++) begin
      seq_nxt[i] = mk_ent(ACT_WAIT, 8'h00);
    end

    case (kind_r)
      KIND_START: begin
        if (len_r != 16'd0) begin
          // abandon an open write
          if (wa_r) begin
            if (!aai_r) begin
              seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00); n = n + 4'd1;
            end else if (st_r) begin
              seq_nxt[n] = mk_ent(ACT_SEND, OP_WRDI); n = n + 4'd1;
              seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);  n = n + 4'd1;
            end
          end
          wa_nxt  = 1'b1;
          hv_nxt  = 1'b0;
          st_nxt  = 1'b0;
          aai_nxt = (device_id_r == ID_AAI);
          na_nxt  = addr_r;
          fa_nxt  = addr_r + {8'h00, len_r} - 24'd1;
          bl_nxt  = len_r;
          off_nxt = start_off;
          seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00); n = n + 4'd1;
          if (device_id_r != ID_AAI) begin
            seq_nxt[n] = mk_ent(ACT_SEND, OP_WREN);        n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);         n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00);          n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, OP_BP);          n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, addr_r[23:16]);  n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, addr_r[15:8]);   n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, addr_r[7:0]);    n = n + 4'd1;
          end
        end
      end

      KIND_DATA: begin
        if (wa_r && !aai_r) begin
          // page program byte
          seq_nxt[n] = mk_ent(ACT_SEND, dbyte_r); n = n + 4'd1;
          na_nxt  = na_r + 24'd1;
          bl_nxt  = bl_r - 16'd1;
          // offset restarts at a page end and where the address wraps to zero
          off_nxt = (off_r == OFF_LAST || na_nxt == 24'd0) ? '0 : off_r + OFF_W'(1);
          if (bl_nxt == 16'd0) begin
            seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00); n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00);  n = n + 4'd1;
            wa_nxt = 1'b0;
          end else if (off_nxt == '0) begin
            // page boundary: new program command
            seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);         n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00);          n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, OP_WREN);        n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);         n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00);          n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, OP_BP);          n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, na_nxt[23:16]);  n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, na_nxt[15:8]);   n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, na_nxt[7:0]);    n = n + 4'd1;
          end
        end else if (wa_r && !hv_r && (bl_r == 16'd1 || na_r[0])) begin
          // single byte program
          seq_nxt[n] = mk_ent(ACT_SEND, OP_WREN);        n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);         n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_SEND, OP_BP);          n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_SEND, bp_addr[23:16]); n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_SEND, bp_addr[15:8]);  n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_SEND, bp_addr[7:0]);   n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_SEND, dbyte_r);        n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);         n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00);          n = n + 4'd1;
          na_nxt = na_r + 24'd1;
          bl_nxt = bl_r - 16'd1;
          if (bl_nxt == 16'd0) begin
            wa_nxt = 1'b0;
          end
        end else if (wa_r && !hv_r) begin
          // first byte of a pair waits for its partner
          hb_nxt = dbyte_r;
          hv_nxt = 1'b1;
        end else if (wa_r) begin
          // pair in auto-increment mode
          if (!st_r) begin
            seq_nxt[n] = mk_ent(ACT_SEND, OP_WREN);      n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);       n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, OP_AAI);       n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, na_r[23:16]);  n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, na_r[15:8]);   n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_SEND, na_r[7:0]);    n = n + 4'd1;
            st_nxt = 1'b1;
          end else begin
            seq_nxt[n] = mk_ent(ACT_SEND, OP_AAI); n = n + 4'd1;
          end
          seq_nxt[n] = mk_ent(ACT_SEND, hb_r);    n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_SEND, dbyte_r); n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);  n = n + 4'd1;
          seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00);   n = n + 4'd1;
          hv_nxt = 1'b0;
          na_nxt = na_r + 24'd2;
          bl_nxt = bl_r - 16'd2;
          if (bl_nxt < 16'd2) begin
            seq_nxt[n] = mk_ent(ACT_SEND, OP_WRDI); n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);  n = n + 4'd1;
            st_nxt = 1'b0;
            if (bl_nxt == 16'd0) begin
              wa_nxt = 1'b0;
            end
          end
        end
      end

      KIND_ERASE: begin
        // abandon an open write
        if (wa_r) begin
          if (!aai_r) begin
            seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00); n = n + 4'd1;
          end else if (st_r) begin
            seq_nxt[n] = mk_ent(ACT_SEND, OP_WRDI); n = n + 4'd1;
            seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);  n = n + 4'd1;
          end
        end
        wa_nxt = 1'b0;
        hv_nxt = 1'b0;
        st_nxt = 1'b0;
        seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00);         n = n + 4'd1;
        seq_nxt[n] = mk_ent(ACT_SEND, OP_WREN);       n = n + 4'd1;
        seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);        n = n + 4'd1;
        seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00);         n = n + 4'd1;
        seq_nxt[n] = mk_ent(ACT_SEND, OP_ERASE);      n = n + 4'd1;
        seq_nxt[n] = mk_ent(ACT_SEND, addr_r[23:16]); n = n + 4'd1;
        seq_nxt[n] = mk_ent(ACT_SEND, addr_r[15:8]);  n = n + 4'd1;
        seq_nxt[n] = mk_ent(ACT_SEND, addr_r[7:0]);   n = n + 4'd1;
        seq_nxt[n] = mk_ent(ACT_RAISE, 8'h00);        n = n + 4'd1;
        seq_nxt[n] = mk_ent(ACT_WAIT, 8'h00);         n = n + 4'd1;
      end

      default: begin
        n = 4'd0;
      end
    endcase
  end

  // state update when the held request is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_r  <= 1'b0;
      aai_r <= 1'b0;
      na_r  <= 24'h0;
      fa_r  <= 24'h0;
      bl_r  <= 16'h0;
      hb_r  <= 8'h00;
      hv_r  <= 1'b0;
      st_r  <= 1'b0;
      off_r <= '0;
    end else if (load) begin
      wa_r  <= wa_nxt;
      aai_r <= aai_nxt;
      na_r  <= na_nxt;
      fa_r  <= fa_nxt;
      bl_r  <= bl_nxt;
      hb_r  <= hb_nxt;
      hv_r  <= hv_nxt;
      st_r  <= st_nxt;
      off_r <= off_nxt;
    end
  end

  // action queue
  ent_t       seq_r [MAX_ACTS];
  logic [3:0] cnt_r;
  logic [3:0] idx_r;
  logic       seq_valid_r;
  ent_t       cur;

  assign cur        = seq_r[idx_r];
  assign out_tvalid = seq_valid_r;
  assign out_tuser  = cur.action;
  assign out_tdata  = cur.data;
  assign out_tlast  = (idx_r == cnt_r - 4'd1);
  assign out_go     = out_tvalid && out_tready;
  assign seq_free   = !seq_valid_r || (out_go && out_tlast);
  assign load       = in_valid_r && seq_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_valid_r <= 1'b0;
      cnt_r       <= 4'd0;
      idx_r       <= 4'd0;
    end else if (load && n != 4'd0) begin
      seq_valid_r <= 1'b1;
      cnt_r       <= n;
      idx_r       <= 4'd0;
    end else if (out_go && out_tlast) begin
      seq_valid_r <= 1'b0;
    end else if (out_go) begin
      idx_r <= idx_r + 4'd1;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (load && n != 4'd0) begin
      for (int i = 0; i < MAX_ACTS; i++) begin
        seq_r[i] <= seq_nxt[i];
      end
    end
  end

endmodule
